// ===== rtl/fptm_pkg.sv =====
// Shared types and constants of the fan PWM and tach meter block.
`default_nettype none

package fptm_pkg;

    // Width of the saturating tach edge counter.
    localparam int EDGE_COUNT_BITS = 20;

    // Field and register widths.
    localparam int CMD_W     = 2;
    localparam int REQ_W     = 7;
    localparam int PCT_W     = 7;
    localparam int COUNT_W   = 16;
    localparam int RPM_W     = 16;
    localparam int WIN_W     = 16;
    localparam int PPR_W     = 4;
    localparam int BITS_W    = 5;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;

    // Arithmetic widths.
    localparam int MS_PER_MIN_W = 16;
    localparam int RPM_NUM_W    = EDGE_COUNT_BITS + MS_PER_MIN_W;  // edges * 60000
    localparam int RPM_DEN_W    = PPR_W + WIN_W;                   // ppr * elapsed
    localparam int DUTY_PROD_W  = PCT_W + COUNT_W;                 // percent * full scale
    localparam int NUM_W        = EDGE_COUNT_BITS + 18;            // 2*num + den
    localparam int DEN_W        = RPM_DEN_W + 1;                   // 2*den
    localparam int REM_W        = DEN_W + 1;
    localparam int QUO_W        = 16;
    localparam int STEP_CNT_W   = $clog2(NUM_W + 1);

    localparam logic [MS_PER_MIN_W-1:0] MS_PER_MINUTE = MS_PER_MIN_W'(60000);
    localparam logic [PCT_W-1:0]        PERCENT_FULL  = PCT_W'(100);
    localparam logic [BITS_W-1:0]       BITS_MAX      = BITS_W'(16);

    // Configuration reset values.
    localparam logic [WIN_W-1:0]  WINDOW_RST = WIN_W'(1000);
    localparam logic [PPR_W-1:0]  PPR_RST    = PPR_W'(2);
    localparam logic [BITS_W-1:0] BITS_RST   = BITS_W'(8);

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK = 2'd0,
        CMD_TACH = 2'd1,
        CMD_DUTY = 2'd2,
        CMD_NONE = 2'd3
    } fptm_cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WINDOW_MS = 2'd0,
        REG_PULSES    = 2'd1,
        REG_PWM_BITS  = 2'd2,
        REG_UNUSED    = 2'd3
    } fptm_reg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_START,
        ST_RUN,
        ST_DONE
    } fptm_state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } fptm_div_stat_t;

endpackage

`default_nettype wire

// ===== rtl/fptm_sdiv.sv =====
// Bit-serial restoring divider with a quotient saturated to 16 bits.
`default_nettype none

module fptm_sdiv (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               start,
    input  wire logic [fptm_pkg::NUM_W-1:0]         dividend,
    input  wire logic [fptm_pkg::DEN_W-1:0]         divisor,
    output logic      [fptm_pkg::QUO_W-1:0]         quotient,
    output fptm_pkg::fptm_div_stat_t                stat
);

    logic [fptm_pkg::STEP_CNT_W-1:0] cnt_reg;
    logic                            done_reg;
    logic [fptm_pkg::NUM_W-1:0]      dvd_reg;
    logic [fptm_pkg::DEN_W-1:0]      dvs_reg;
    logic [fptm_pkg::REM_W-1:0]      rem_reg;
    logic [fptm_pkg::QUO_W-1:0]      quo_reg;
    logic                            ovf_reg;

    logic [fptm_pkg::REM_W-1:0]      rem_shift;
    logic                            fits;
    logic [fptm_pkg::REM_W-1:0]      rem_next;

    // One quotient bit per cycle, most significant first.
    assign rem_shift = {rem_reg[fptm_pkg::REM_W-2:0], dvd_reg[fptm_pkg::NUM_W-1]};
    assign fits      = rem_shift >= fptm_pkg::REM_W'(dvs_reg);
    assign rem_next  = fits ? rem_shift - fptm_pkg::REM_W'(dvs_reg) : rem_shift;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= (cnt_reg == fptm_pkg::STEP_CNT_W'(1));
            if (start) begin
                cnt_reg <= fptm_pkg::STEP_CNT_W'(fptm_pkg::NUM_W);
            end else if (cnt_reg != '0) begin
                cnt_reg <= cnt_reg - fptm_pkg::STEP_CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            dvd_reg <= dividend;
            dvs_reg <= divisor;
            rem_reg <= '0;
            quo_reg <= '0;
            ovf_reg <= 1'b0;
        end else if (cnt_reg != '0) begin
            dvd_reg <= {dvd_reg[fptm_pkg::NUM_W-2:0], 1'b0};
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[fptm_pkg::QUO_W-2:0], fits};
            ovf_reg <= ovf_reg | quo_reg[fptm_pkg::QUO_W-1];
        end
    end

    assign quotient  = ovf_reg ? '1 : quo_reg;
    assign stat.busy = (cnt_reg != '0);
    assign stat.done = done_reg;

endmodule

`default_nettype wire

// ===== rtl/fan_pwm_tach_meter_top.sv =====
// Top level of the fan PWM duty and tach rpm meter.
//
//  Channel   Ports                                       Direction  Beat
//  s_        s_valid s_ready s_command s_duty_request    in         one item
//  m_        m_valid m_ready m_duty_percent m_duty_count out        one result
//            m_rpm m_rpm_updated
//  cfg_      cfg_valid cfg_ready cfg_index cfg_data      in         one register write
//
// Every input beat gives exactly one result beat. From acceptance an item passes through
// forming the products, loading the dividers, NUM_W (38) steps of the two bit-serial
// dividers that run side by side, seeing them finish and registering the result.
// The next input beat is taken only after that, so a new item is not taken before the
// last one is through. The serial dividers set the pace.
// Reset is synchronous on aresetn low: counters clear, registers return to their
// defaults and the window starts. A stalled m_ready holds the result register; the
// next input beat is taken while a result still waits, and its result waits in turn.
`default_nettype none

module fan_pwm_tach_meter_top (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,

    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire logic [fptm_pkg::CMD_W-1:0]      s_command,
    input  wire logic [fptm_pkg::REQ_W-1:0]      s_duty_request,

    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic      [fptm_pkg::PCT_W-1:0]      m_duty_percent,
    output logic      [fptm_pkg::COUNT_W-1:0]    m_duty_count,
    output logic      [fptm_pkg::RPM_W-1:0]      m_rpm,
    output logic                                 m_rpm_updated,

    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [fptm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [fptm_pkg::CFG_DAT_W-1:0]  cfg_data
);

    fptm_pkg::fptm_state_t state_reg, state_next;

    // Configuration registers.
    logic [fptm_pkg::WIN_W-1:0]  window_reg;
    logic [fptm_pkg::PPR_W-1:0]  ppr_reg;
    logic [fptm_pkg::BITS_W-1:0] bits_reg;

    // Measurement state.
    logic [fptm_pkg::WIN_W-1:0]             elapsed_reg;
    logic [fptm_pkg::EDGE_COUNT_BITS-1:0]   edge_reg;
    logic [fptm_pkg::PCT_W-1:0]             pct_reg;
    logic [fptm_pkg::RPM_W-1:0]             last_rpm_reg;

    // Per-item work registers.
    logic                                   close_reg;
    logic [fptm_pkg::EDGE_COUNT_BITS-1:0]   win_edges_reg;
    logic [fptm_pkg::WIN_W-1:0]        win_dt_reg;
    logic [fptm_pkg::RPM_NUM_W-1:0]    rpm_num_reg;
    logic [fptm_pkg::RPM_DEN_W-1:0]    rpm_den_reg;
    logic                              rpm_zero_reg;
    logic [fptm_pkg::DUTY_PROD_W-1:0]  duty_prod_reg;

    // Result register.
    logic                              m_valid_reg;
    logic [fptm_pkg::PCT_W-1:0]        m_duty_percent_reg;
    logic [fptm_pkg::COUNT_W-1:0]      m_duty_count_reg;
    logic [fptm_pkg::RPM_W-1:0]        m_rpm_reg;
    logic                              m_rpm_updated_reg;

    logic                              accept;
    logic                              div_start;
    logic                              out_load;
    logic [fptm_pkg::WIN_W-1:0]        win_eff;
    logic [fptm_pkg::WIN_W-1:0]        elapsed_inc;
    logic                              close_now;
    logic [fptm_pkg::BITS_W-1:0]       bits_eff;
    logic [fptm_pkg::COUNT_W:0]        full_wide;
    logic [fptm_pkg::COUNT_W-1:0]      full_scale;
    logic [fptm_pkg::PCT_W-1:0]        req_sat;
    logic [fptm_pkg::NUM_W-1:0]        rpm_dividend;
    logic [fptm_pkg::DEN_W-1:0]        rpm_divisor;
    logic [fptm_pkg::QUO_W-1:0]        rpm_quo;
    logic [fptm_pkg::QUO_W-1:0]        duty_quo;
    logic [fptm_pkg::RPM_W-1:0]        rpm_new;
    fptm_pkg::fptm_div_stat_t          rpm_stat;
    fptm_pkg::fptm_div_stat_t          duty_stat;

    // Handshakes: config is always taken; input only between items.
    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == fptm_pkg::ST_IDLE);
    assign accept    = s_valid && s_ready;

    // Window bookkeeping: a zero window behaves as one tick.
    assign win_eff     = (window_reg == '0) ? fptm_pkg::WIN_W'(1) : window_reg;
    assign elapsed_inc = (elapsed_reg != '1) ? elapsed_reg + fptm_pkg::WIN_W'(1)
                                             : elapsed_reg;
    assign close_now   = (elapsed_inc >= win_eff);

    // Clamp the duty request to full on.
    assign req_sat = (s_duty_request > fptm_pkg::PERCENT_FULL) ? fptm_pkg::PERCENT_FULL
                                                               : s_duty_request;

    // PWM full scale is 2^bits - 1, bits clamped to 16; zero bits give zero.
    assign bits_eff   = (bits_reg > fptm_pkg::BITS_MAX) ? fptm_pkg::BITS_MAX : bits_reg;
    assign full_wide  = (fptm_pkg::COUNT_W+1)'(1) << bits_eff;
    assign full_scale = fptm_pkg::COUNT_W'(full_wide - (fptm_pkg::COUNT_W+1)'(1));

    // Rounded quotient: (2*num + den) / (2*den).
    assign rpm_dividend = fptm_pkg::NUM_W'({rpm_num_reg, 1'b0})
                        + fptm_pkg::NUM_W'(rpm_den_reg);
    assign rpm_divisor  = {rpm_den_reg, 1'b0};

    // Sequencer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= fptm_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        div_start  = 1'b0;
        out_load   = 1'b0;
        case (state_reg)
            fptm_pkg::ST_IDLE: begin
                if (accept) begin
                    state_next = fptm_pkg::ST_PREP;
                end
            end
            fptm_pkg::ST_PREP: begin
                state_next = fptm_pkg::ST_START;
            end
            fptm_pkg::ST_START: begin
                div_start  = 1'b1;
                state_next = fptm_pkg::ST_RUN;
            end
            fptm_pkg::ST_RUN: begin
                if (duty_stat.done) begin
                    state_next = fptm_pkg::ST_DONE;
                end
            end
            fptm_pkg::ST_DONE: begin
                // Hold until the result register is free or being emptied.
                if (!m_valid_reg || m_ready) begin
                    out_load   = 1'b1;
                    state_next = fptm_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = fptm_pkg::ST_IDLE;
            end
        endcase
    end

    // Configuration writes; an unused index is dropped.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_reg <= fptm_pkg::WINDOW_RST;
            ppr_reg    <= fptm_pkg::PPR_RST;
            bits_reg   <= fptm_pkg::BITS_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (fptm_pkg::fptm_reg_idx_t'(cfg_index))
                fptm_pkg::REG_WINDOW_MS: window_reg <= cfg_data;
                fptm_pkg::REG_PULSES:    ppr_reg    <= cfg_data[fptm_pkg::PPR_W-1:0];
                fptm_pkg::REG_PWM_BITS:  bits_reg   <= cfg_data[fptm_pkg::BITS_W-1:0];
                default: ;
            endcase
        end
    end

    // Apply the command to the counters on acceptance.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            elapsed_reg  <= '0;
            edge_reg     <= '0;
            pct_reg      <= '0;
            last_rpm_reg <= '0;
            close_reg    <= 1'b0;
        end else begin
            if (accept) begin
                close_reg <= (s_command == fptm_pkg::CMD_TICK) && close_now;
                case (fptm_pkg::fptm_cmd_t'(s_command))
                    fptm_pkg::CMD_TICK: begin
                        if (close_now) begin
                            // Close the window and restart both counters.
                            elapsed_reg <= '0;
                            edge_reg    <= '0;
                        end else begin
                            elapsed_reg <= elapsed_inc;
                        end
                    end
                    fptm_pkg::CMD_TACH: begin
                        if (edge_reg != '1) begin
                            edge_reg <= edge_reg + fptm_pkg::EDGE_COUNT_BITS'(1);
                        end
                    end
                    fptm_pkg::CMD_DUTY: begin
                        pct_reg <= req_sat;
                    end
                    default: ;
                endcase
            end
            if (out_load && close_reg) begin
                last_rpm_reg <= rpm_new;
            end
        end
    end

    // Capture the closed window's figures.
    always_ff @(posedge aclk) begin
        if (accept && close_now) begin
            win_edges_reg <= edge_reg;
            win_dt_reg    <= elapsed_inc;
        end
    end

    // Form the dividends: one multiply per product, registered.
    always_ff @(posedge aclk) begin
        if (state_reg == fptm_pkg::ST_PREP) begin
            rpm_num_reg   <= fptm_pkg::RPM_NUM_W'(win_edges_reg)
                           * fptm_pkg::RPM_NUM_W'(fptm_pkg::MS_PER_MINUTE);
            rpm_den_reg   <= fptm_pkg::RPM_DEN_W'(ppr_reg)
                           * fptm_pkg::RPM_DEN_W'(win_dt_reg);
            rpm_zero_reg  <= (win_edges_reg == '0) || (ppr_reg == '0);
            duty_prod_reg <= fptm_pkg::DUTY_PROD_W'(pct_reg)
                           * fptm_pkg::DUTY_PROD_W'(full_scale);
        end
    end

    fptm_sdiv u_rpm_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (rpm_dividend),
        .divisor  (rpm_divisor),
        .quotient (rpm_quo),
        .stat     (rpm_stat)
    );

    fptm_sdiv u_duty_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (fptm_pkg::NUM_W'(duty_prod_reg)),
        .divisor  (fptm_pkg::DEN_W'(fptm_pkg::PERCENT_FULL)),
        .quotient (duty_quo),
        .stat     (duty_stat)
    );

    // No edges or no pulses per revolution force zero.
    assign rpm_new = rpm_zero_reg ? '0 : rpm_quo;

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_duty_percent_reg <= pct_reg;
            m_duty_count_reg   <= duty_quo;
            m_rpm_reg          <= close_reg ? rpm_new : last_rpm_reg;
            m_rpm_updated_reg  <= close_reg;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_duty_percent = m_duty_percent_reg;
    assign m_duty_count   = m_duty_count_reg;
    assign m_rpm          = m_rpm_reg;
    assign m_rpm_updated  = m_rpm_updated_reg;

    // Input is taken only while both dividers rest.
    a_idle_divs: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> (!rpm_stat.busy && !duty_stat.busy))
        else $error("input taken while a divider is busy");

    // The two dividers always run in lockstep.
    a_lockstep: assert property (@(posedge aclk) disable iff (!aresetn)
        rpm_stat.done == duty_stat.done)
        else $error("dividers out of step");

    // A result appears only after the finishing state.
    a_load_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(state_reg == fptm_pkg::ST_DONE))
        else $error("result loaded outside the finishing state");

    // Closing a window restarts both counters.
    a_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_command == fptm_pkg::CMD_TICK && close_now)
            |=> (elapsed_reg == '0 && edge_reg == '0 && close_reg))
        else $error("window did not restart");

endmodule

`default_nettype wire
